/* hw/rtl/fmrs_pkg.sv */
// Shared types, constants and the F-number table for the score stream FM register sequencer.
// Used by fmrs_front, fmrs_queue, fmrs_back and the top level; depends on nothing.
package fmrs_pkg;

    localparam int SPEED_W         = 16;
    localparam int DELAY_HI_W      = 7;
    localparam int DELAY_W         = 24;
    localparam int PROD_W          = DELAY_HI_W + 8 + SPEED_W;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [SPEED_W-1:0] SPEED_RESET    = 16'd256;
    localparam logic [DELAY_W-1:0] NOTE_OFF_DELAY = 24'd20;

    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
    localparam logic [3:0] CMD_RESTART  = 4'hE;
    localparam logic [3:0] CMD_STOP     = 4'hF;

    localparam logic [3:0] ADDR_FNUM_LO = 4'h1;
    localparam logic [3:0] ADDR_KEY_OCT = 4'h2;

    localparam logic [7:0] OCT_TOP_NOTE  = 8'd107;
    localparam logic [2:0] OCT_MAX       = 3'd7;
    localparam logic [7:0] RECIP12_MUL   = 8'd171;
    localparam int         RECIP12_SHIFT = 11;
    localparam logic [7:0] NOTES_PER_OCT = 8'd12;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_ADVANCE = 2'd1,
        KIND_STOP    = 2'd2,
        KIND_RESTART = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_CMD      = 2'd0,
        PH_NOTE     = 2'd1,
        PH_DELAY_LO = 2'd2
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] chan;
        logic [7:0] data_lo;
        logic [7:0] data_hi;
    } t_cmd;

    function automatic logic [8:0] fnum_lookup(input logic [3:0] idx);
        logic [8:0] f;
        case (idx)
            4'd0:    f = 9'd172;
            4'd1:    f = 9'd181;
            4'd2:    f = 9'd192;
            4'd3:    f = 9'd204;
            4'd4:    f = 9'd216;
            4'd5:    f = 9'd229;
            4'd6:    f = 9'd242;
            4'd7:    f = 9'd257;
            4'd8:    f = 9'd272;
            4'd9:    f = 9'd288;
            4'd10:   f = 9'd305;
            4'd11:   f = 9'd323;
            default: f = 9'd0;
        endcase
        return f;
    endfunction

endpackage

/* hw/rtl/fmrs_front.sv */
// Front end: accepts score bytes and ticks, tracks parse phase, delay and tick count,
// and turns each item that causes results into one command. Depends on fmrs_pkg.
module fmrs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [fmrs_pkg::SPEED_W-1:0]  i_cfg_wr_data,
    input  logic                          i_accept,
    input  logic                          i_mode,
    input  logic [7:0]                    i_score_byte,
    output logic                          o_push,
    output fmrs_pkg::t_cmd                o_cmd
);

    fmrs_pkg::t_phase                  r_phase, n_phase;
    logic [fmrs_pkg::SPEED_W-1:0]      r_speed;
    logic [3:0]                        r_chan, n_chan;
    logic [fmrs_pkg::DELAY_HI_W-1:0]   r_delay_hi, n_delay_hi;
    logic [fmrs_pkg::DELAY_W-1:0]      r_delay, n_delay;
    logic [fmrs_pkg::DELAY_W-1:0]      r_tick, n_tick;

    logic [15:0]                       q_prod;
    logic [4:0]                        note_q;
    logic [7:0]                        note_r;
    logic [8:0]                        fnum;
    logic [2:0]                        oct;
    logic [fmrs_pkg::PROD_W-1:0]       delay_prod;
    logic [3:0]                        cmd_code;

    assign q_prod     = 16'(i_score_byte) * 16'(fmrs_pkg::RECIP12_MUL);
    assign note_q     = q_prod[15:fmrs_pkg::RECIP12_SHIFT];
    assign note_r     = i_score_byte - 8'(note_q) * fmrs_pkg::NOTES_PER_OCT;
    assign fnum       = fmrs_pkg::fnum_lookup(note_r[3:0]);
    assign oct        = (i_score_byte > fmrs_pkg::OCT_TOP_NOTE) ? fmrs_pkg::OCT_MAX
                                                                : note_q[2:0];
    assign delay_prod = fmrs_pkg::PROD_W'({r_delay_hi, i_score_byte})
                      * fmrs_pkg::PROD_W'(r_speed);
    assign cmd_code   = i_score_byte[7:4];

    always_comb begin
        n_phase = r_phase;
        if (i_accept && !i_mode) begin
            unique case (r_phase)
                fmrs_pkg::PH_NOTE:     n_phase = fmrs_pkg::PH_CMD;
                fmrs_pkg::PH_DELAY_LO: n_phase = fmrs_pkg::PH_CMD;
                default: begin
                    if (cmd_code == fmrs_pkg::CMD_NOTE_ON) begin
                        n_phase = fmrs_pkg::PH_NOTE;
                    end else if (!i_score_byte[7]) begin
                        n_phase = fmrs_pkg::PH_DELAY_LO;
                    end else begin
                        n_phase = fmrs_pkg::PH_CMD;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_chan     = r_chan;
        n_delay_hi = r_delay_hi;
        n_delay    = r_delay;
        n_tick     = r_tick;
        o_push     = 1'b0;
        o_cmd      = '{kind: fmrs_pkg::KIND_WRITE, chan: r_chan, data_lo: 8'd0, data_hi: 8'd0};
        if (i_accept) begin
            if (i_mode) begin
                if (r_tick > r_delay) begin
                    n_tick     = '0;
                    o_push     = 1'b1;
                    o_cmd.kind = fmrs_pkg::KIND_ADVANCE;
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end else begin
                unique case (r_phase)
                    fmrs_pkg::PH_NOTE: begin
                        o_push        = 1'b1;
                        o_cmd.data_lo = fnum[7:0];
                        o_cmd.data_hi = {3'b000, 1'b1, oct, fnum[8]};
                    end
                    fmrs_pkg::PH_DELAY_LO: begin
                        n_delay = fmrs_pkg::DELAY_W'(delay_prod[fmrs_pkg::PROD_W-1:8]);
                    end
                    default: begin
                        unique case (cmd_code)
                            fmrs_pkg::CMD_NOTE_ON: begin
                                n_chan = i_score_byte[3:0];
                            end
                            fmrs_pkg::CMD_NOTE_OFF: begin
                                o_push     = 1'b1;
                                o_cmd.chan = i_score_byte[3:0];
                                n_delay    = fmrs_pkg::NOTE_OFF_DELAY;
                            end
                            fmrs_pkg::CMD_STOP: begin
                                o_push     = 1'b1;
                                o_cmd.kind = fmrs_pkg::KIND_STOP;
                            end
                            fmrs_pkg::CMD_RESTART: begin
                                o_push     = 1'b1;
                                o_cmd.kind = fmrs_pkg::KIND_RESTART;
                                n_delay    = '0;
                                n_tick     = '0;
                            end
                            default: begin
                                if (!i_score_byte[7]) begin
                                    n_delay_hi = i_score_byte[6:0];
                                end
                            end
                        endcase
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= fmrs_pkg::PH_CMD;
            r_speed    <= fmrs_pkg::SPEED_RESET;
            r_chan     <= '0;
            r_delay_hi <= '0;
            r_delay    <= '0;
            r_tick     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_chan     <= n_chan;
            r_delay_hi <= n_delay_hi;
            r_delay    <= n_delay;
            r_tick     <= n_tick;
            if (i_cfg_wr_en) begin
                r_speed <= i_cfg_wr_data;
            end
        end
    end

endmodule

/* hw/rtl/fmrs_queue.sv */
// Short command queue between the front end and the result sequencer.
// Register based, one push and one pop a cycle; a push while full or a pop while empty is ignored.
module fmrs_queue #(
    parameter int DEPTH = fmrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fmrs_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output fmrs_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fmrs_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

/* hw/rtl/fmrs_back.sv */
// Result sequencer: expands each queued command into one or two result words
// and holds them in an output register. Depends on fmrs_pkg.
module fmrs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fmrs_pkg::t_cmd i_head,
    input  logic           i_empty,
    output logic           o_pop,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_reg_addr,
    output logic [7:0]     o_reg_data,
    output logic           o_last
);

    logic             r_valid, n_valid;
    logic             r_second, n_second;
    fmrs_pkg::t_kind  r_kind, n_kind;
    logic [7:0]       r_addr, n_addr;
    logic [7:0]       r_data, n_data;
    logic             r_last, n_last;
    logic             load;
    logic             is_write;

    assign load     = !r_valid || !i_out_stall;
    assign is_write = (i_head.kind == fmrs_pkg::KIND_WRITE);

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_kind   = r_kind;
        n_addr   = r_addr;
        n_data   = r_data;
        n_last   = r_last;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = 1'b0;
            if (r_second) begin
                n_valid  = 1'b1;
                n_kind   = fmrs_pkg::KIND_WRITE;
                n_addr   = {fmrs_pkg::ADDR_KEY_OCT, i_head.chan};
                n_data   = i_head.data_hi;
                n_last   = 1'b1;
                n_second = 1'b0;
                o_pop    = 1'b1;
            end else if (!i_empty) begin
                n_valid = 1'b1;
                n_kind  = i_head.kind;
                n_addr  = is_write ? {fmrs_pkg::ADDR_FNUM_LO, i_head.chan} : 8'd0;
                n_data  = is_write ? i_head.data_lo : 8'd0;
                n_last  = !is_write;
                if (is_write) begin
                    n_second = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_addr <= n_addr;
        r_data <= n_data;
        r_last <= n_last;
    end

    assign o_out_valid = r_valid;
    assign o_kind      = r_kind;
    assign o_reg_addr  = r_addr;
    assign o_reg_data  = r_data;
    assign o_last      = r_last;

endmodule

/* hw/rtl/score_stream_fm_register_sequencer_unit.sv */
// Score stream FM register sequencer top level, built from fmrs_front, fmrs_queue, fmrs_back.
// Throughput: one input item per cycle while the queue has room; one result word per cycle
// while not stalled. A command is registered in the queue, then in the output register as its
// first word; a note-on's second word follows. The queue depth sets how far the two sides slip.
// Reset: synchronous active low; clears parse state, delay, tick count, queue and output valid,
// and sets the speed reciprocal to 1.0.
module score_stream_fm_register_sequencer_unit #(
    parameter int QUEUE_DEPTH = fmrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [fmrs_pkg::SPEED_W-1:0] i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_mode,
    input  logic [7:0]                   i_score_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_kind,
    output logic [7:0]                   o_reg_addr,
    output logic [7:0]                   o_reg_data,
    output logic                         o_last
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    fmrs_pkg::t_cmd cmd;
    fmrs_pkg::t_cmd head;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    fmrs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_mode        (i_mode),
        .i_score_byte  (i_score_byte),
        .o_push        (push),
        .o_cmd         (cmd)
    );

    fmrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    fmrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_reg_addr  (o_reg_addr),
        .o_reg_data  (o_reg_data),
        .o_last      (o_last)
    );

endmodule
